### hdl/rift_pkg.sv
// ----------------------------------------------------------------------------
// rift_pkg: shared types and constants of the run interval filter table
// Widths, operation codes, the request format passed from the front end to
// the table engine, and the table status group.
// ----------------------------------------------------------------------------
package rift_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int COUNT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W        = 31;
    localparam int CHAR_W       = 8;
    localparam int OP_W         = 2;
    localparam int COUNT_OUT_W  = 9;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W    = 1;

    localparam logic [VAL_W-1:0]  THRESHOLD_RESET = 31'd100000;
    localparam logic [VAL_W-1:0]  VAL_MAX         = {VAL_W{1'b1}};
    localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE       = 8'h39;

    localparam logic [CFG_IDX_W-1:0] CFG_USE_FILTER    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_THRESHOLD = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_FLUSH = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_kind_t;

    // For a query, run and low carry the asked run and section.
    typedef struct packed {
        cmd_kind_t        kind;
        logic [VAL_W-1:0] run;
        logic [VAL_W-1:0] low;
        logic [VAL_W-1:0] high;
    } cmd_t;

    typedef struct packed {
        logic               overflow;
        logic [COUNT_W-1:0] count;
    } tbl_stat_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_SCAN = 1'b1
    } back_state_t;

endpackage

### hdl/rift_front.sv
// ----------------------------------------------------------------------------
// rift_front: list parser and request classifier
// Accumulates decimal numbers from load characters, tracks the current run
// and pending range start, and queues store and query requests.
// ----------------------------------------------------------------------------
module rift_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rift_pkg::OP_W-1:0]     operation,
    input  logic [rift_pkg::CHAR_W-1:0]   char_byte,
    input  logic [rift_pkg::VAL_W-1:0]    query_run,
    input  logic [rift_pkg::VAL_W-1:0]    query_section,
    input  logic [rift_pkg::VAL_W-1:0]    run_threshold,
    input  logic                          q_full,
    output logic                          q_push,
    output rift_pkg::cmd_t                q_cmd
);

    localparam int PROD_W = rift_pkg::VAL_W + 4;

    logic [rift_pkg::VAL_W-1:0] accum_reg, accum_next;
    logic                       in_number_reg, in_number_next;
    logic [rift_pkg::VAL_W-1:0] current_run_reg, current_run_next;
    logic [rift_pkg::VAL_W-1:0] range_start_reg, range_start_next;
    logic                       have_start_reg, have_start_next;

    logic              accept;
    logic              is_digit;
    logic [3:0]        digit;
    logic [PROD_W-1:0] prod;
    logic              finish;
    logic              store;
    logic              query;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_digit = (char_byte >= rift_pkg::CHAR_ZERO) && (char_byte <= rift_pkg::CHAR_NINE);
    assign digit    = 4'(char_byte - rift_pkg::CHAR_ZERO);
    // accum * 10 + digit as two shifts and adds.
    assign prod     = (PROD_W'(accum_reg) << 3) + (PROD_W'(accum_reg) << 1) + PROD_W'(digit);

    always_comb begin
        finish = 1'b0;
        query  = 1'b0;
        unique case (operation)
            rift_pkg::OP_LOAD:  finish = accept && !is_digit && in_number_reg;
            rift_pkg::OP_FLUSH: finish = accept && in_number_reg;
            rift_pkg::OP_QUERY: query  = accept;
            default: ;
        endcase
    end

    assign store = finish && (accum_reg <= run_threshold) && have_start_reg;

    always_comb begin
        accum_next       = accum_reg;
        in_number_next   = in_number_reg;
        current_run_next = current_run_reg;
        range_start_next = range_start_reg;
        have_start_next  = have_start_reg;
        if (accept && (operation == rift_pkg::OP_LOAD) && is_digit) begin
            accum_next     = (prod > PROD_W'(rift_pkg::VAL_MAX)) ? rift_pkg::VAL_MAX
                                                              : prod[rift_pkg::VAL_W-1:0];
            in_number_next = 1'b1;
        end
        if (finish) begin
            accum_next     = '0;
            in_number_next = 1'b0;
            if (accum_reg > run_threshold) begin
                current_run_next = accum_reg;
            end else if (!have_start_reg) begin
                range_start_next = accum_reg;
                have_start_next  = 1'b1;
            end else begin
                have_start_next  = 1'b0;
            end
        end
    end

    always_comb begin
        q_push = query || store;
        if (query) begin
            q_cmd = '{kind: rift_pkg::CMD_QUERY, run: query_run, low: query_section,
                      high: '0};
        end else begin
            q_cmd = '{kind: rift_pkg::CMD_STORE, run: current_run_reg, low: range_start_reg,
                      high: accum_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg       <= '0;
            in_number_reg   <= 1'b0;
            current_run_reg <= '0;
            range_start_reg <= '0;
            have_start_reg  <= 1'b0;
        end else begin
            accum_reg       <= accum_next;
            in_number_reg   <= in_number_next;
            current_run_reg <= current_run_next;
            range_start_reg <= range_start_next;
            have_start_reg  <= have_start_next;
        end
    end

endmodule

### hdl/rift_queue.sv
// ----------------------------------------------------------------------------
// rift_queue: request queue between front end and table engine
// A small first-in first-out buffer of requests so that parsing and table
// scans stall independently.
// ----------------------------------------------------------------------------
module rift_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rift_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output rift_pkg::cmd_t head_cmd,
    output logic           empty
);

    rift_pkg::cmd_t slot_reg [rift_pkg::QUEUE_DEPTH];

    logic [rift_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rift_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [rift_pkg::QFILL_W-1:0] fill_reg, fill_next;
    logic                         do_push, do_pop;

    assign full     = (fill_reg == rift_pkg::QFILL_W'(rift_pkg::QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### hdl/rift_back.sv
// ----------------------------------------------------------------------------
// rift_back: range table engine
// Stores ranges into the table memory and answers filtered queries by scanning
// stored entries one per cycle while out_free, with a registered result stage.
// ----------------------------------------------------------------------------
module rift_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               use_filter,
    input  logic                               q_empty,
    input  rift_pkg::cmd_t                     q_cmd,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               out_is_good,
    output logic                               out_overflowed,
    output logic [rift_pkg::COUNT_OUT_W-1:0]   out_entry_count,
    output rift_pkg::tbl_stat_t                stat
);

    typedef struct packed {
        logic [rift_pkg::VAL_W-1:0] run;
        logic [rift_pkg::VAL_W-1:0] low;
        logic [rift_pkg::VAL_W-1:0] high;
    } entry_t;

    entry_t mem [rift_pkg::TABLE_DEPTH];
    entry_t rd_data_reg;

    rift_pkg::back_state_t state_reg, state_next;

    logic [rift_pkg::COUNT_W-1:0] count_reg;
    logic                         overflow_reg;
    logic [rift_pkg::COUNT_W-1:0] idx_reg;
    logic                         rd_valid_reg;
    logic [rift_pkg::VAL_W-1:0]   q_run_reg, q_sec_reg;

    logic                               out_valid_reg;
    logic                               out_good_reg;
    logic                               out_ovf_reg;
    logic [rift_pkg::COUNT_OUT_W-1:0]   out_count_reg;

    logic out_free;
    logic table_full;
    logic more;
    logic hit;
    logic mem_we;
    logic set_overflow;
    logic start_scan;
    logic issue;
    logic res_load;
    logic res_good;

    assign out_free   = !out_valid_reg || out_ready;
    assign table_full = (count_reg == rift_pkg::COUNT_W'(rift_pkg::TABLE_DEPTH));
    assign more       = (idx_reg != count_reg);
    assign hit        = rd_valid_reg && (rd_data_reg.run == q_run_reg)
                        && (q_sec_reg >= rd_data_reg.low) && (q_sec_reg <= rd_data_reg.high);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rift_pkg::BK_IDLE: begin
                if (!q_empty && (q_cmd.kind == rift_pkg::CMD_QUERY) && use_filter) begin
                    state_next = rift_pkg::BK_SCAN;
                end
            end
            rift_pkg::BK_SCAN: begin
                if (out_free && (hit || !more)) begin
                    state_next = rift_pkg::BK_IDLE;
                end
            end
            default: state_next = rift_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        set_overflow = 1'b0;
        start_scan   = 1'b0;
        issue        = 1'b0;
        res_load     = 1'b0;
        res_good     = 1'b0;
        unique case (state_reg)
            rift_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    if (q_cmd.kind == rift_pkg::CMD_STORE) begin
                        q_pop        = 1'b1;
                        mem_we       = !table_full;
                        set_overflow = table_full;
                    end else if (use_filter) begin
                        q_pop      = 1'b1;
                        start_scan = 1'b1;
                    end else if (out_free) begin
                        // Filtering off: every query is good.
                        q_pop    = 1'b1;
                        res_load = 1'b1;
                        res_good = 1'b1;
                    end
                end
            end
            rift_pkg::BK_SCAN: begin
                issue    = out_free && more;
                res_load = out_free && (hit || !more);
                res_good = hit;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[rift_pkg::ADDR_W-1:0]] <= '{run: q_cmd.run, low: q_cmd.low,
                                                      high: q_cmd.high};
        end
        if (issue) begin
            rd_data_reg <= mem[idx_reg[rift_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (start_scan) begin
            q_run_reg <= q_cmd.run;
            q_sec_reg <= q_cmd.low;
        end
        if (res_load) begin
            out_good_reg  <= res_good;
            out_ovf_reg   <= overflow_reg;
            out_count_reg <= rift_pkg::COUNT_OUT_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rift_pkg::BK_IDLE;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mem_we) begin
                count_reg <= count_reg + 1'b1;
            end
            if (set_overflow) begin
                overflow_reg <= 1'b1;
            end
            if (start_scan) begin
                idx_reg <= '0;
            end else if (issue) begin
                idx_reg <= idx_reg + 1'b1;
            end
            // A stalled scan keeps its pending read data.
            if (!((state_reg == rift_pkg::BK_SCAN) && !out_free)) begin
                rd_valid_reg <= issue;
            end
            if (res_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_is_good     = out_good_reg;
    assign out_overflowed  = out_ovf_reg;
    assign out_entry_count = out_count_reg;
    assign stat            = '{overflow: overflow_reg, count: count_reg};

endmodule

### hdl/run_interval_filter_table.sv
// ----------------------------------------------------------------------------
// run_interval_filter_table: good-section list loader and run/section filter
// Parses a list of run numbers and section ranges into a table and answers
// run/section queries against it.
// ----------------------------------------------------------------------------
// Load and end-of-load items are taken one per cycle while the 4-entry request
// queue has room; the table engine stores a range from its idle state.
// A query result is registered when the scan of the stored ranges (0 to 256),
// one per cycle through the table memory read port while the output is free,
// hits or ends, or straight from the queue when filtering is off.
// Reset (aresetn low, synchronous) clears parser, queue, counters and flags;
// table memory contents are not cleared, the entry count starts at zero.
module run_interval_filter_table (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // char_byte [7:0], query_run [38:8], query_section [69:39], zero fill
    input  logic [71:0]                         s_tdata,
    // operation [1:0]
    input  logic [rift_pkg::OP_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // is_good [0], overflowed [1], entry_count [10:2], zero fill
    output logic [15:0]                         m_tdata,
    input  logic                                cfg_we,
    input  logic [rift_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rift_pkg::VAL_W-1:0]          cfg_wdata
);

    logic                          use_filter_reg;
    logic [rift_pkg::VAL_W-1:0]    run_threshold_reg;

    logic                          q_push, q_full, q_pop, q_empty;
    rift_pkg::cmd_t                push_cmd, head_cmd;
    rift_pkg::tbl_stat_t           stat;
    logic                          is_good, overflowed;
    logic [rift_pkg::COUNT_OUT_W-1:0] entry_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_filter_reg    <= 1'b0;
            run_threshold_reg <= rift_pkg::THRESHOLD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rift_pkg::CFG_USE_FILTER:    use_filter_reg    <= cfg_wdata[0];
                rift_pkg::CFG_RUN_THRESHOLD: run_threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    rift_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .operation     (s_tuser),
        .char_byte     (s_tdata[7:0]),
        .query_run     (s_tdata[38:8]),
        .query_section (s_tdata[69:39]),
        .run_threshold (run_threshold_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    rift_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    rift_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .use_filter      (use_filter_reg),
        .q_empty         (q_empty),
        .q_cmd           (head_cmd),
        .q_pop           (q_pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_is_good     (is_good),
        .out_overflowed  (overflowed),
        .out_entry_count (entry_count),
        .stat            (stat)
    );

    assign m_tdata = {5'b0, entry_count, overflowed, is_good};

    // Once a range has been dropped, the flag never clears.
    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.overflow |=> stat.overflow)
        else $error("overflow flag cleared");

    // Ranges are only dropped when the table is full.
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.overflow |-> (stat.count == rift_pkg::COUNT_W'(rift_pkg::TABLE_DEPTH)))
        else $error("overflow with free table entries");

    // The table grows by at most one range per cycle and never shrinks.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.count == $past(stat.count))
        || (stat.count == $past(stat.count) + rift_pkg::COUNT_W'(1)))
        else $error("entry count jumped");

endmodule

### tb/tb_run_interval_filter_table.sv
// ----------------------------------------------------------------------------
// tb_run_interval_filter_table: self-checking bench for the run interval filter
// Feeds good-section list text, end-of-load marks and run/section queries
// through the request stream, predicts every query answer in the bench and
// compares each answer field against the oldest prediction, over several
// filter settings, run thresholds and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_run_interval_filter_table;
    timeunit 1ns;
    timeprecision 1ps;

    import rift_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int FINAL_CYCLES  = 300;
    localparam longint LIMIT_NS  = 20_000_000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [VAL_W-1:0]  run;
        logic [VAL_W-1:0]  sec;
    } request_t;

    typedef struct packed {
        logic                   good;
        logic                   over;
        logic [COUNT_OUT_W-1:0] count;
    } answer_t;

    typedef struct packed {
        logic [VAL_W-1:0] run;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
    } aimed_range_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [71:0]          s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VAL_W-1:0]     cfg_wdata = '0;

    // Bench copy of the block state.
    logic             filt_on;
    logic [VAL_W-1:0] run_limit;
    logic [VAL_W-1:0] num_acc;
    logic             in_num;
    logic [VAL_W-1:0] cur_run;
    logic [VAL_W-1:0] rng_lo;
    logic             have_lo;
    logic [VAL_W-1:0] tab_run [TABLE_DEPTH];
    logic [VAL_W-1:0] tab_lo  [TABLE_DEPTH];
    logic [VAL_W-1:0] tab_hi  [TABLE_DEPTH];
    int               tab_count;
    logic             tab_over;

    request_t     pending_requests[$];
    answer_t      answers_due[$];
    aimed_range_t aimed_ranges[$];
    logic [VAL_W-1:0] known_runs[$];
    logic [VAL_W-1:0] gen_run;

    int  items_queued = 0;
    int  accepted_count = 0;
    int  fail_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic s_taken = 1'b0;

    run_interval_filter_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void close_number();
        logic [VAL_W-1:0] n;
        n = num_acc;
        in_num = 1'b0;
        num_acc = '0;
        if (n > run_limit) begin
            cur_run = n;
        end else if (!have_lo) begin
            rng_lo = n;
            have_lo = 1'b1;
        end else begin
            have_lo = 1'b0;
            if (tab_count < TABLE_DEPTH) begin
                tab_run[tab_count] = cur_run;
                tab_lo[tab_count] = rng_lo;
                tab_hi[tab_count] = n;
                tab_count++;
            end else begin
                tab_over = 1'b1;
            end
        end
    endfunction

    function automatic void take_char(logic [CHAR_W-1:0] ch);
        logic [VAL_W-1:0] d;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            d = VAL_W'(ch - CHAR_ZERO);
            // The guard keeps num_acc * 10 + d inside 31 bits.
            if (num_acc > (VAL_MAX - d) / 10)
                num_acc = VAL_MAX;
            else
                num_acc = num_acc * 10 + d;
            in_num = 1'b1;
        end else if (in_num) begin
            close_number();
        end
    endfunction

    function automatic logic section_good(logic [VAL_W-1:0] run, logic [VAL_W-1:0] sec);
        if (!filt_on)
            return 1'b1;
        for (int i = 0; i < tab_count; i++) begin
            if (tab_run[i] == run && sec >= tab_lo[i] && sec <= tab_hi[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void filter_step(request_t req);
        answer_t ans;
        case (req.op)
            OP_LOAD: take_char(req.ch);
            OP_FLUSH: begin
                if (in_num)
                    close_number();
            end
            OP_QUERY: begin
                ans.good = section_good(req.run, req.sec);
                ans.over = tab_over;
                ans.count = COUNT_OUT_W'(tab_count);
                answers_due.push_back(ans);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver and monitor
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_requests
        request_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                req = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {2'b00, req.sec, req.run, req.ch};
                s_tuser <= req.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : watch_results
        answer_t  want;
        request_t req;
        s_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    $error("answer with no query waiting: m_tdata=%h", m_tdata);
                    fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (m_tdata[0] !== want.good) begin
                        $error("is_good: expected %0b, got %0b", want.good, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[1] !== want.over) begin
                        $error("overflowed: expected %0b, got %0b", want.over, m_tdata[1]);
                        fail_count++;
                    end
                    if (m_tdata[10:2] !== want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count, m_tdata[10:2]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                req.op = s_tuser;
                req.ch = s_tdata[7:0];
                req.run = s_tdata[38:8];
                req.sec = s_tdata[69:39];
                filter_step(req);
                accepted_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                            logic [VAL_W-1:0] run, logic [VAL_W-1:0] sec);
        request_t req;
        req.op = op;
        req.ch = ch;
        req.run = run;
        req.sec = sec;
        pending_requests.push_back(req);
        items_queued++;
    endtask

    task automatic push_char(logic [CHAR_W-1:0] ch);
        push_req(OP_LOAD, ch, VAL_W'($urandom()), VAL_W'($urandom()));
    endtask

    function automatic logic [CHAR_W-1:0] pick_sep();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(7))
            0: return 8'h20;
            1: return 8'h2C;
            2: return 8'h2D;
            3: return 8'h3A;
            4: return 8'h0A;
            5: return 8'h2F;
            default: begin
                do c = CHAR_W'($urandom()); while (c >= CHAR_ZERO && c <= CHAR_NINE);
                return c;
            end
        endcase
    endfunction

    task automatic push_number(logic [VAL_W-1:0] v);
        string txt;
        int k;
        if ($urandom_range(9) == 0)
            push_char(CHAR_ZERO);
        txt = $sformatf("%0d", v);
        for (k = 0; k < txt.len(); k++)
            push_char(txt[k]);
        push_char(pick_sep());
    endtask

    function automatic logic [VAL_W-1:0] pick_bound();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return run_limit;
        if (r < 20)
            return VAL_W'($urandom_range(0, run_limit));
        return VAL_W'($urandom_range(0, (run_limit < 40) ? run_limit : 40));
    endfunction

    // Only called while some number can still exceed the threshold.
    function automatic logic [VAL_W-1:0] pick_run_id();
        longint span;
        longint v;
        int unsigned r;
        span = longint'(VAL_MAX) - longint'(run_limit);
        r = $urandom_range(99);
        if (r < 50)
            v = longint'(run_limit) + 1 + $urandom_range(0, (span > 8) ? 7 : span - 1);
        else if (r < 65)
            v = VAL_MAX;
        else
            v = longint'(run_limit) + 1 + ($urandom() % span);
        return VAL_W'(v);
    endfunction

    task automatic remember(aimed_range_t ar);
        if (aimed_ranges.size() < 64)
            aimed_ranges.push_back(ar);
        else
            aimed_ranges[$urandom_range(63)] = ar;
    endtask

    task automatic add_range();
        aimed_range_t ar;
        longint t;
        ar.run = gen_run;
        ar.lo = pick_bound();
        if ($urandom_range(9) == 0) begin
            ar.hi = pick_bound();
        end else begin
            t = longint'(ar.lo) + $urandom_range(0, 5);
            ar.hi = (t > run_limit) ? run_limit : VAL_W'(t);
        end
        push_number(ar.lo);
        push_number(ar.hi);
        remember(ar);
    endtask

    // A well-formed piece of list text: an optional run followed by ranges.
    task automatic add_list_block();
        if (run_limit != VAL_MAX && $urandom_range(99) < 40) begin
            gen_run = pick_run_id();
            push_number(gen_run);
            if (known_runs.size() < 32)
                known_runs.push_back(gen_run);
            else
                known_runs[$urandom_range(31)] = gen_run;
        end
        repeat ($urandom_range(1, 4)) add_range();
    endtask

    task automatic add_query();
        aimed_range_t ar;
        logic [VAL_W-1:0] qr;
        logic [VAL_W-1:0] qs;
        int unsigned r;
        r = $urandom_range(99);
        if (aimed_ranges.size() > 0 && r < 70) begin
            ar = aimed_ranges[$urandom_range(aimed_ranges.size() - 1)];
            qr = ar.run;
            if (ar.hi >= ar.lo)
                qs = ar.lo + VAL_W'($urandom_range(0, ar.hi - ar.lo));
            else
                qs = ar.lo;
            case ($urandom_range(9))
                0: qr = ar.run + 1;
                1: qs = ar.hi + 1;
                2: qs = ar.lo - 1;
                default: ;
            endcase
        end else if (r < 85) begin
            qr = known_runs[$urandom_range(known_runs.size() - 1)];
            qs = pick_bound();
        end else begin
            qr = VAL_W'($urandom());
            qs = VAL_W'($urandom());
        end
        push_req(OP_QUERY, CHAR_W'($urandom()), qr, qs);
    endtask

    task automatic run_random_phase(int n_items);
        int start;
        int goal;
        int unsigned r;
        start = items_queued;
        goal = n_items;
        while (items_queued - start < goal) begin
            r = $urandom_range(99);
            if (r < 55) begin
                add_list_block();
            end else if (r < 80) begin
                add_query();
            end else if (r < 90) begin
                if ($urandom_range(1))
                    push_char(CHAR_W'($urandom()));
                else
                    push_char(CHAR_ZERO + CHAR_W'($urandom_range(9)));
            end else if (r < 95) begin
                push_req(OP_FLUSH, CHAR_W'($urandom()), VAL_W'($urandom()), VAL_W'($urandom()));
            end else if (r < 97) begin
                push_req(OP_UNUSED, CHAR_W'($urandom()), VAL_W'($urandom()),
                         VAL_W'($urandom()));
                goal++;
            end else begin
                // Broken text: an overlong number or a lone bound, ended abruptly.
                if ($urandom_range(1)) begin
                    repeat ($urandom_range(10, 12))
                        push_char(CHAR_ZERO + CHAR_W'($urandom_range(9)));
                end else begin
                    push_number(pick_bound());
                end
                if ($urandom_range(1))
                    push_req(OP_FLUSH, '0, '0, '0);
                else
                    push_char(pick_sep());
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == CFG_USE_FILTER)
            filt_on = value[0];
        else
            run_limit = value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge aclk); while (accepted_count != items_queued || answers_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        filt_on = 1'b0;
        run_limit = THRESHOLD_RESET;
        num_acc = '0;
        in_num = 1'b0;
        cur_run = '0;
        rng_lo = '0;
        have_lo = 1'b0;
        tab_count = 0;
        tab_over = 1'b0;
        gen_run = '0;
        known_runs.push_back('0);

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Filtering is off after reset: an empty table still answers good.
        push_req(OP_QUERY, 8'hFF, VAL_MAX, VAL_MAX);
        drain();
        write_reg(CFG_USE_FILTER, 31'd1);

        // Range before any run, with low above high, closed by end of load.
        push_char(8'h37);
        push_char(8'hFF);
        push_char(8'h33);
        push_req(OP_FLUSH, '0, '0, '0);
        push_req(OP_FLUSH, '0, '0, '0);
        push_req(OP_UNUSED, 8'h35, VAL_MAX, VAL_MAX);
        push_req(OP_QUERY, 8'h00, '0, 31'd5);
        // An overlong run number saturates, then a range against it.
        repeat (10) push_char(CHAR_NINE);
        push_char(8'h00);
        push_char(CHAR_ZERO);
        push_char(8'h3A);
        push_char(CHAR_NINE);
        push_char(8'h2F);
        push_req(OP_QUERY, '0, VAL_MAX, 31'd9);
        push_req(OP_QUERY, '0, VAL_MAX, VAL_MAX);
        push_req(OP_QUERY, '0, VAL_MAX, '0);
        drain();

        set_idling(0, 0);
        run_random_phase(200);
        drain();

        write_reg(CFG_RUN_THRESHOLD, 31'd9);
        set_idling(63, 0);
        run_random_phase(450);
        drain();

        write_reg(CFG_USE_FILTER, 31'd0);
        write_reg(CFG_RUN_THRESHOLD, 31'd0);
        set_idling(0, 63);
        run_random_phase(300);
        drain();

        write_reg(CFG_USE_FILTER, 31'd1);
        write_reg(CFG_RUN_THRESHOLD, VAL_MAX);
        set_idling(32, 32);
        run_random_phase(350);
        drain();

        // Push the table past full so that later ranges are dropped.
        write_reg(CFG_RUN_THRESHOLD, 31'd50);
        set_idling(0, 0);
        push_req(OP_FLUSH, '0, '0, '0);
        repeat (TABLE_DEPTH + 8 - tab_count) add_range();
        run_random_phase(250);
        drain();

        repeat (FINAL_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
hdl/rift_pkg.sv
hdl/rift_front.sv
hdl/rift_queue.sv
hdl/rift_back.sv
hdl/run_interval_filter_table.sv
tb/tb_run_interval_filter_table.sv
